// File: design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the ARP frame sanity classifier.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam logic [31:0] VLAN_ID_MASK  = 32'h0000_0FFF;
   localparam logic [15:0] ETYPE_ARP     = 16'h0806;
   localparam logic [15:0] ETYPE_RARP    = 16'h8035;
   localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
   localparam logic [15:0] ETYPE_TRAILER = 16'h1000;
   localparam logic [15:0] HW_ETHER      = 16'd1;
   localparam logic [15:0] HW_IEEE802    = 16'd6;
   localparam logic [7:0]  MAC_ADDR_LEN  = 8'd6;
   localparam logic [7:0]  IP_ADDR_LEN   = 8'd4;
   localparam logic [15:0] OP_REQ        = 16'd1;
   localparam logic [15:0] OP_REP        = 16'd2;
   localparam logic [15:0] OP_RREQ       = 16'd3;
   localparam logic [15:0] OP_RREP       = 16'd4;

   typedef enum logic [3:0] {
      V_OK        = 4'd0,
      V_SHORT     = 4'd1,
      V_BADHW     = 4'd2,
      V_BADPROTO  = 4'd3,
      V_BADLEN    = 4'd4,
      V_WRONGOP   = 4'd5,
      V_RARPREQ   = 4'd6,
      V_WRONGRARP = 4'd7,
      V_BADTYPE   = 4'd8,
      V_BOGON     = 4'd9,
      V_BCAST     = 4'd10,
      V_MISMATCH  = 4'd11
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_BOGON_CHECK_OFF = 3'd0,
      CSR_LOCAL_NET       = 3'd1,
      CSR_LOCAL_MASK      = 3'd2,
      CSR_EXTRA_NET_COUNT = 3'd3,
      CSR_EXTRA_NET_A     = 3'd4,
      CSR_EXTRA_MASK_A    = 3'd5,
      CSR_EXTRA_NET_B     = 3'd6,
      CSR_EXTRA_MASK_B    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] inner_etype;
      logic [31:0] vlan_tag;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_addr_len;
      logic [7:0]  proto_addr_len;
      logic [15:0] arp_opcode;
      logic [47:0] frame_src_mac;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [11:0] vlan_id;
      logic [31:0] ip_out;
      logic [47:0] mac_out;
   } rsp_type;

   typedef struct packed {
      logic        bogon_check_off;
      logic [31:0] local_net;
      logic [31:0] local_mask;
      logic [1:0]  extra_net_count;
      logic [31:0] extra_net_a;
      logic [31:0] extra_mask_a;
      logic [31:0] extra_net_b;
      logic [31:0] extra_mask_b;
   } net_cfg_type;

   // raw check outcomes, resolved by priority in the next stage
   typedef struct packed {
      logic frame_short;
      logic bad_hw;
      logic bad_proto;
      logic bad_len;
      logic is_arp;
      logic is_rarp;
      logic arp_op_ok;
      logic rarp_req;
      logic rarp_op_ok;
      logic bogon;
      logic bcast;
      logic mismatch;
   } check_flags_type;

   typedef struct packed {
      logic [11:0] vlan_id;
      logic [31:0] ip;
      logic [47:0] mac;
   } pass_type;

endpackage

// File: design/arpc_check.sv
// ----------------------------------------------------------------------------
// arpc_check
// Evaluates every header check in parallel and registers the flag set.
// ----------------------------------------------------------------------------
module arpc_check #(
   parameter int MIN_FRAME_BYTES = 46
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  arpc_pkg::req_type          in_req,
   input  arpc_pkg::net_cfg_type      cfg,
   output logic                       out_valid,
   input  logic                       out_ready,
   output arpc_pkg::check_flags_type  out_flags,
   output arpc_pkg::pass_type         out_pass
);
   import arpc_pkg::*;

   logic            valid_ff;
   check_flags_type flags_ff;
   check_flags_type flags_in;
   pass_type        pass_ff;
   pass_type        pass_in;
   logic            load;
   logic            in_local;
   logic            in_extra_a;
   logic            in_extra_b;
   logic            mac_src_special;
   logic            mac_snd_special;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      in_local   = (in_req.sender_ip & cfg.local_mask) == cfg.local_net;
      // a count of three saturates to two
      in_extra_a = (cfg.extra_net_count != 2'd0) &&
                   ((in_req.sender_ip & cfg.extra_mask_a) == cfg.extra_net_a);
      in_extra_b = cfg.extra_net_count[1] &&
                   ((in_req.sender_ip & cfg.extra_mask_b) == cfg.extra_net_b);
      mac_src_special = (in_req.frame_src_mac == '0) || (in_req.frame_src_mac == '1);
      mac_snd_special = (in_req.sender_mac == '0) || (in_req.sender_mac == '1);

      flags_in.frame_short = in_req.frame_length < 16'(MIN_FRAME_BYTES);
      flags_in.bad_hw      = (in_req.hw_type != HW_ETHER) && (in_req.hw_type != HW_IEEE802);
      flags_in.bad_proto   = (in_req.proto_type != ETYPE_IPV4) &&
                             (in_req.proto_type != ETYPE_TRAILER);
      flags_in.bad_len     = (in_req.hw_addr_len != MAC_ADDR_LEN) ||
                             (in_req.proto_addr_len != IP_ADDR_LEN);
      flags_in.is_arp      = in_req.inner_etype == ETYPE_ARP;
      flags_in.is_rarp     = in_req.inner_etype == ETYPE_RARP;
      flags_in.arp_op_ok   = (in_req.arp_opcode == OP_REQ) || (in_req.arp_opcode == OP_REP);
      flags_in.rarp_req    = in_req.arp_opcode == OP_RREQ;
      flags_in.rarp_op_ok  = in_req.arp_opcode == OP_RREP;
      flags_in.bogon       = !cfg.bogon_check_off && !in_local && !in_extra_a && !in_extra_b;
      flags_in.bcast       = mac_src_special || mac_snd_special;
      flags_in.mismatch    = in_req.frame_src_mac != in_req.sender_mac;

      pass_in.vlan_id = 12'(in_req.vlan_tag & VLAN_ID_MASK);
      pass_in.ip      = in_req.sender_ip;
      pass_in.mac     = in_req.frame_src_mac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_in;
         pass_ff  <= pass_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_pass  = pass_ff;

endmodule

// File: design/arpc_resolve.sv
// ----------------------------------------------------------------------------
// arpc_resolve
// Priority-encodes the check flags into one verdict; output register stage.
// ----------------------------------------------------------------------------
module arpc_resolve (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  arpc_pkg::check_flags_type  in_flags,
   input  arpc_pkg::pass_type         in_pass,
   output logic                       out_valid,
   input  logic                       out_ready,
   output arpc_pkg::rsp_type          out_rsp
);
   import arpc_pkg::*;

   logic        valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   verdict_type tail;
   logic        load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      // checks that follow a valid opcode
      if (in_flags.bogon) begin
         tail = V_BOGON;
      end else if (in_flags.bcast) begin
         tail = V_BCAST;
      end else if (in_flags.mismatch) begin
         tail = V_MISMATCH;
      end else begin
         tail = V_OK;
      end

      if (in_flags.frame_short) begin
         rsp_in.verdict = V_SHORT;
      end else if (in_flags.bad_hw) begin
         rsp_in.verdict = V_BADHW;
      end else if (in_flags.bad_proto) begin
         rsp_in.verdict = V_BADPROTO;
      end else if (in_flags.bad_len) begin
         rsp_in.verdict = V_BADLEN;
      end else if (in_flags.is_arp) begin
         rsp_in.verdict = in_flags.arp_op_ok ? tail : V_WRONGOP;
      end else if (in_flags.is_rarp) begin
         if (in_flags.rarp_req) begin
            rsp_in.verdict = V_RARPREQ;
         end else if (!in_flags.rarp_op_ok) begin
            rsp_in.verdict = V_WRONGRARP;
         end else begin
            rsp_in.verdict = tail;
         end
      end else begin
         rsp_in.verdict = V_BADTYPE;
      end

      rsp_in.vlan_id = in_pass.vlan_id;
      rsp_in.ip_out  = in_pass.ip;
      rsp_in.mac_out = in_pass.mac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: design/arp_frame_sanity_classifier.sv
// ----------------------------------------------------------------------------
// arp_frame_sanity_classifier
// Per-frame sanity verdict for parsed VLAN-tagged ARP/RARP headers.
// ----------------------------------------------------------------------------
// Takes one frame header per cycle while the output is not stalled and returns
// one verdict per frame, in order, with the VLAN id, sender IP and source MAC
// passed along. There are three register stages: an input register, a stage
// that runs all field and subnet compares in parallel, and a stage that
// resolves them by priority into the output register. Each stage holds when
// the next one is full and stalled, so sustained throughput is one frame per
// clock while rsp_ready stays high.
// The net registers are written through the csr port (always ready) and must
// only change while no frame is in flight.
module arp_frame_sanity_classifier #(
   parameter int MIN_FRAME_BYTES = 46
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  arpc_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output arpc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  arpc_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata
);
   import arpc_pkg::*;

   net_cfg_type     cfg_ff;
   net_cfg_type     cfg_in;
   logic            in_valid_ff;
   req_type         in_req_ff;
   logic            chk_in_ready;
   logic            chk_valid;
   logic            chk_ready;
   check_flags_type chk_flags;
   pass_type        chk_pass;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BOGON_CHECK_OFF: cfg_in.bogon_check_off = csr_wdata[0];
            CSR_LOCAL_NET:       cfg_in.local_net       = csr_wdata;
            CSR_LOCAL_MASK:      cfg_in.local_mask      = csr_wdata;
            CSR_EXTRA_NET_COUNT: cfg_in.extra_net_count = csr_wdata[1:0];
            CSR_EXTRA_NET_A:     cfg_in.extra_net_a     = csr_wdata;
            CSR_EXTRA_MASK_A:    cfg_in.extra_mask_a    = csr_wdata;
            CSR_EXTRA_NET_B:     cfg_in.extra_net_b     = csr_wdata;
            CSR_EXTRA_MASK_B:    cfg_in.extra_mask_b    = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register stage
   assign req_ready = !in_valid_ff || chk_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_data;
      end
   end

   arpc_check #(
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (chk_in_ready),
      .in_req    (in_req_ff),
      .cfg       (cfg_ff),
      .out_valid (chk_valid),
      .out_ready (chk_ready),
      .out_flags (chk_flags),
      .out_pass  (chk_pass)
   );

   arpc_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_flags  (chk_flags),
      .in_pass   (chk_pass),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

   // backpressure only reaches the input when every stage is full and stalled
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && chk_valid && rsp_valid && !rsp_ready))
      else $error("req_ready low while pipeline has room");

   // a drained pipeline emits nothing next cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !chk_valid && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
      else $error("rsp_valid without a frame in flight");

   // short frames win over every other check
   a_short_first: assert property (@(posedge clock) disable iff (reset)
      (chk_valid && chk_ready && chk_flags.frame_short) |=>
         (rsp_valid && rsp_data.verdict == V_SHORT))
      else $error("short frame not reported as short");

   // a transfer into the resolve stage lands in the output register
   a_pass_vlan: assert property (@(posedge clock) disable iff (reset)
      (chk_valid && chk_ready) |=> (rsp_data.vlan_id == $past(chk_pass.vlan_id)))
      else $error("vlan id lost in resolve stage");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARP frame sanity classifier.
// ----------------------------------------------------------------------------
// Frame headers go in on the req channel and a verdict comes back for each one.
// At every req transfer the bench predicts the verdict from its own copy of
// the net registers and queues it. Each rsp transfer is checked field by
// field against the oldest queued verdict. Net settings are reprogrammed only
// while the pipeline is empty. Directed frames cover each verdict and the
// priority order. Random phases then run under varied sender idling,
// receiver stalls, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import arpc_pkg::*;

   localparam int MIN_FRAME = 46;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_BOGON_CHECK_OFF;
   logic [31:0]   csr_wdata = '0;

   net_cfg_type   net_shadow = '0;
   rsp_type       verdicts_due[$];
   int            error_count = 0;
   int            sender_idle_pct = 0;
   int            rsp_stall_pct = 0;
   bit            hold_pending = 1'b0;
   int            hold_left = 0;

   arp_frame_sanity_classifier #(.MIN_FRAME_BYTES(MIN_FRAME)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic rsp_type classify_frame(input req_type f, input net_cfg_type c);
      rsp_type     r;
      logic [1:0]  nets;
      logic [31:0] vid;
      bit          known;
      vid       = f.vlan_tag & VLAN_ID_MASK;
      r.vlan_id = vid[11:0];
      r.ip_out  = f.sender_ip;
      r.mac_out = f.frame_src_mac;
      // a count of three saturates to the two extra nets that exist
      nets  = (c.extra_net_count > 2'd2) ? 2'd2 : c.extra_net_count;
      known = ((f.sender_ip & c.local_mask) == c.local_net) ||
              (nets >= 2'd1 && (f.sender_ip & c.extra_mask_a) == c.extra_net_a) ||
              (nets >= 2'd2 && (f.sender_ip & c.extra_mask_b) == c.extra_net_b);
      if (int'(f.frame_length) < MIN_FRAME)
         r.verdict = V_SHORT;
      else if (f.hw_type != HW_ETHER && f.hw_type != HW_IEEE802)
         r.verdict = V_BADHW;
      else if (f.proto_type != ETYPE_IPV4 && f.proto_type != ETYPE_TRAILER)
         r.verdict = V_BADPROTO;
      else if (f.hw_addr_len != MAC_ADDR_LEN || f.proto_addr_len != IP_ADDR_LEN)
         r.verdict = V_BADLEN;
      else if (f.inner_etype == ETYPE_ARP && f.arp_opcode != OP_REQ && f.arp_opcode != OP_REP)
         r.verdict = V_WRONGOP;
      else if (f.inner_etype == ETYPE_RARP && f.arp_opcode == OP_RREQ)
         r.verdict = V_RARPREQ;
      else if (f.inner_etype == ETYPE_RARP && f.arp_opcode != OP_RREP)
         r.verdict = V_WRONGRARP;
      else if (f.inner_etype != ETYPE_ARP && f.inner_etype != ETYPE_RARP)
         r.verdict = V_BADTYPE;
      else if (!c.bogon_check_off && !known)
         r.verdict = V_BOGON;
      else if (f.frame_src_mac == '0 || f.frame_src_mac == '1 ||
               f.sender_mac == '0 || f.sender_mac == '1)
         r.verdict = V_BCAST;
      else if (f.frame_src_mac != f.sender_mac)
         r.verdict = V_MISMATCH;
      else
         r.verdict = V_OK;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [47:0] rand_mac();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [31:0] ip_in_net(input logic [31:0] net, input logic [31:0] mask);
      return (net & mask) | ($urandom & ~mask);
   endfunction

   function automatic req_type good_frame(input logic [31:0] ip);
      req_type f;
      f.frame_length   = 16'd60;
      f.inner_etype    = ETYPE_ARP;
      f.vlan_tag       = $urandom;
      f.hw_type        = HW_ETHER;
      f.proto_type     = ETYPE_IPV4;
      f.hw_addr_len    = MAC_ADDR_LEN;
      f.proto_addr_len = IP_ADDR_LEN;
      f.arp_opcode     = OP_REQ;
      f.frame_src_mac  = {8'h02, $urandom, 8'h01};
      f.sender_mac     = f.frame_src_mac;
      f.sender_ip      = ip;
      return f;
   endfunction

   // mostly well-formed frames aimed at the programmed nets, some noise
   function automatic req_type random_frame();
      req_type f;
      f = good_frame($urandom);
      case ($urandom_range(9))
         0:       f.frame_length = 16'($urandom);
         1:       f.frame_length = 16'(MIN_FRAME - 1);
         2:       f.frame_length = 16'(MIN_FRAME);
         default: f.frame_length = 16'($urandom_range(MIN_FRAME, 1518));
      endcase
      f.hw_type    = $urandom_range(1) ? HW_ETHER : HW_IEEE802;
      f.proto_type = $urandom_range(1) ? ETYPE_IPV4 : ETYPE_TRAILER;
      if ($urandom_range(9) < 6) begin
         f.inner_etype = ETYPE_ARP;
         f.arp_opcode  = $urandom_range(1) ? OP_REQ : OP_REP;
      end else begin
         f.inner_etype = ETYPE_RARP;
         f.arp_opcode  = ($urandom_range(3) == 0) ? OP_RREQ : OP_RREP;
      end
      case ($urandom_range(3))
         0: f.sender_ip = ip_in_net(net_shadow.local_net, net_shadow.local_mask);
         1: f.sender_ip = ip_in_net(net_shadow.extra_net_a, net_shadow.extra_mask_a);
         2: f.sender_ip = ip_in_net(net_shadow.extra_net_b, net_shadow.extra_mask_b);
         default: f.sender_ip = $urandom;
      endcase
      f.frame_src_mac = rand_mac();
      f.sender_mac    = f.frame_src_mac;
      case ($urandom_range(19))
         0, 1: f.sender_mac = rand_mac();
         2:    f.frame_src_mac = '0;
         3:    f.sender_mac = '1;
         4:    f.frame_src_mac = '1;
         5:    f.sender_mac = '0;
         default: ;
      endcase
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(3) == 0) f.inner_etype    = 16'($urandom);
         if ($urandom_range(3) == 0) f.hw_type        = 16'($urandom);
         if ($urandom_range(3) == 0) f.proto_type     = 16'($urandom);
         if ($urandom_range(3) == 0) f.hw_addr_len    = 8'($urandom);
         if ($urandom_range(3) == 0) f.proto_addr_len = 8'($urandom);
         if ($urandom_range(3) == 0) f.arp_opcode     = 16'($urandom);
         if ($urandom_range(3) == 0) f.frame_length   = 16'($urandom);
      end
      return f;
   endfunction

   function automatic logic [31:0] prefix_mask(input int bits);
      return (bits == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - bits));
   endfunction

   function automatic net_cfg_type random_nets();
      net_cfg_type c;
      c.bogon_check_off = ($urandom_range(9) == 0);
      c.local_mask      = prefix_mask($urandom_range(32));
      c.local_net       = $urandom & c.local_mask;
      c.extra_net_count = 2'($urandom_range(3));
      c.extra_mask_a    = prefix_mask($urandom_range(32));
      c.extra_net_a     = $urandom & c.extra_mask_a;
      c.extra_mask_b    = prefix_mask($urandom_range(32));
      // occasionally a net with host bits set, which never matches
      c.extra_net_b     = ($urandom_range(7) == 0) ? $urandom : ($urandom & c.extra_mask_b);
      return c;
   endfunction

   // ---------------------------------------------------------------- bus tasks
   // Entered and left at a falling edge; valid stays high across back-to-back frames.
   task automatic send_frame(input req_type f);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (!req_ready);
      verdicts_due.push_back(classify_frame(f, net_shadow));
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BOGON_CHECK_OFF: net_shadow.bogon_check_off = value[0];
         CSR_LOCAL_NET:       net_shadow.local_net       = value;
         CSR_LOCAL_MASK:      net_shadow.local_mask      = value;
         CSR_EXTRA_NET_COUNT: net_shadow.extra_net_count = value[1:0];
         CSR_EXTRA_NET_A:     net_shadow.extra_net_a     = value;
         CSR_EXTRA_MASK_A:    net_shadow.extra_mask_a    = value;
         CSR_EXTRA_NET_B:     net_shadow.extra_net_b     = value;
         CSR_EXTRA_MASK_B:    net_shadow.extra_mask_b    = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_nets(input net_cfg_type c);
      wait_idle();
      write_csr(CSR_BOGON_CHECK_OFF, {31'd0, c.bogon_check_off});
      write_csr(CSR_LOCAL_NET, c.local_net);
      write_csr(CSR_LOCAL_MASK, c.local_mask);
      write_csr(CSR_EXTRA_NET_COUNT, {30'd0, c.extra_net_count});
      write_csr(CSR_EXTRA_NET_A, c.extra_net_a);
      write_csr(CSR_EXTRA_MASK_A, c.extra_mask_a);
      write_csr(CSR_EXTRA_NET_B, c.extra_net_b);
      write_csr(CSR_EXTRA_MASK_B, c.extra_mask_b);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int send_pct, input int stall_pct);
      sender_idle_pct = send_pct;
      rsp_stall_pct   = stall_pct;
      repeat (count) send_frame(random_frame());
   endtask

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left    = 80;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $error("unexpected rsp transfer: verdict %0d", rsp_data.verdict);
            error_count++;
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_data.verdict !== due.verdict) begin
               $error("verdict: expected %0d, actual %0d", due.verdict, rsp_data.verdict);
               error_count++;
            end
            if (rsp_data.vlan_id !== due.vlan_id) begin
               $error("vlan_id: expected %0h, actual %0h", due.vlan_id, rsp_data.vlan_id);
               error_count++;
            end
            if (rsp_data.ip_out !== due.ip_out) begin
               $error("ip_out: expected %0h, actual %0h", due.ip_out, rsp_data.ip_out);
               error_count++;
            end
            if (rsp_data.mac_out !== due.mac_out) begin
               $error("mac_out: expected %0h, actual %0h", due.mac_out, rsp_data.mac_out);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   localparam logic [31:0] LAN_IP = 32'hC0A8_0107;

   task automatic test_directed();
      req_type     f;
      net_cfg_type c;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      // reset settings: zero mask puts every address in the local net
      send_frame(good_frame(32'h0808_0808));
      c = '0;
      c.local_net       = 32'hC0A8_0100;
      c.local_mask      = 32'hFFFF_FF00;
      c.extra_net_count = 2'd2;
      c.extra_net_a     = 32'h0A00_0000;
      c.extra_mask_a    = 32'hFF00_0000;
      c.extra_net_b     = 32'hAC10_0000;
      c.extra_mask_b    = 32'hFFF0_0000;
      load_nets(c);
      send_frame(good_frame(LAN_IP));
      f = good_frame(LAN_IP);
      f.hw_type = HW_IEEE802; f.proto_type = ETYPE_TRAILER; f.arp_opcode = OP_REP;
      send_frame(f);
      f = good_frame(LAN_IP); f.inner_etype = ETYPE_RARP; f.arp_opcode = OP_RREP;
      send_frame(f);
      f = good_frame(LAN_IP); f.frame_length = 16'(MIN_FRAME - 1); send_frame(f);
      f = good_frame(LAN_IP); f.frame_length = 16'(MIN_FRAME);     send_frame(f);
      f = good_frame(LAN_IP); f.frame_length = 16'h0000;           send_frame(f);
      f = good_frame(LAN_IP); f.frame_length = 16'hFFFF;           send_frame(f);
      f = good_frame(LAN_IP); f.hw_type = 16'h0000;                send_frame(f);
      f = good_frame(LAN_IP); f.hw_type = 16'hFFFF;                send_frame(f);
      f = good_frame(LAN_IP); f.proto_type = ETYPE_ARP;            send_frame(f);
      f = good_frame(LAN_IP); f.hw_addr_len = 8'd5;                send_frame(f);
      f = good_frame(LAN_IP); f.proto_addr_len = 8'hFF;            send_frame(f);
      f = good_frame(LAN_IP); f.arp_opcode = 16'h0000;             send_frame(f);
      f = good_frame(LAN_IP); f.arp_opcode = OP_RREQ;              send_frame(f);
      // RARP request gets its own verdict but still carries its pass-through fields
      f = good_frame($urandom); f.inner_etype = ETYPE_RARP; f.arp_opcode = OP_RREQ;
      f.vlan_tag = 32'hFFFF_FFFF; f.frame_src_mac = '1;
      send_frame(f);
      f = good_frame(LAN_IP); f.inner_etype = ETYPE_RARP; f.arp_opcode = OP_REQ;
      send_frame(f);
      f = good_frame(LAN_IP); f.inner_etype = ETYPE_RARP; f.arp_opcode = 16'hFFFF;
      send_frame(f);
      f = good_frame(LAN_IP); f.inner_etype = ETYPE_IPV4;          send_frame(f);
      f = good_frame(LAN_IP); f.inner_etype = 16'hFFFF;            send_frame(f);
      send_frame(good_frame(32'h0808_0808));
      send_frame(good_frame(32'h0AFF_0001));
      send_frame(good_frame(32'hAC1F_FFFF));
      f = good_frame(LAN_IP); f.frame_src_mac = '0; f.sender_mac = '0; send_frame(f);
      f = good_frame(LAN_IP); f.sender_mac = '1;                   send_frame(f);
      f = good_frame(LAN_IP); f.sender_mac = f.sender_mac ^ 48'h1; send_frame(f);
      // everything wrong at once: capture length wins
      f = '1; f.frame_length = 16'd0; send_frame(f);
   endtask

   task automatic test_extra_net_count();
      net_cfg_type c;
      c = net_shadow;
      // a count of three behaves as two
      c.extra_net_count = 2'd3;
      load_nets(c);
      send_frame(good_frame(32'hAC12_3456));
      send_frame(good_frame(32'h0A01_0203));
      c.extra_net_count = 2'd1;
      load_nets(c);
      send_frame(good_frame(32'hAC12_3456));
      send_frame(good_frame(32'h0A01_0203));
      c.extra_net_count = 2'd0;
      load_nets(c);
      send_frame(good_frame(32'h0A01_0203));
      send_frame(good_frame(LAN_IP));
      c.bogon_check_off = 1'b1;
      load_nets(c);
      send_frame(good_frame(32'h0808_0808));
      run_random(60, 0, 0);
   endtask

   task automatic test_net_extremes();
      net_cfg_type c;
      c = '1;
      load_nets(c);
      c.bogon_check_off = 1'b0;
      load_nets(c);
      send_frame(good_frame(32'hFFFF_FFFF));
      send_frame(good_frame(32'hFFFF_FFFE));
      run_random(100, 13, 13);
      c = '0;
      load_nets(c);
      run_random(100, 0, 0);
      c = '0;
      c.local_net    = 32'hFFFF_FFFF;
      c.local_mask   = 32'hFFFF_FFFF;
      c.extra_mask_a = 32'hFFFF_FFFF;
      c.extra_mask_b = 32'hFFFF_FFFF;
      c.extra_net_count = 2'd2;
      load_nets(c);
      run_random(100, 13, 13);
   endtask

   task automatic test_idle_mix();
      load_nets(random_nets());
      run_random(220, 0, 0);
      load_nets(random_nets());
      run_random(220, 66, 0);
      load_nets(random_nets());
      run_random(220, 0, 66);
      load_nets(random_nets());
      run_random(220, 13, 13);
   endtask

   task automatic test_backpressure();
      load_nets(random_nets());
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (2) begin
         req_valid <= 1'b0;
         @(posedge clock);
         hold_pending = 1'b1;
         @(negedge clock);
         repeat (120) send_frame(random_frame());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_extra_net_count();
      test_net_extremes();
      test_idle_mix();
      test_backpressure();
      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
